### rtl/gdai_pkg.sv
// Shared types, constants and helper functions of the gyro delta-angle integrator.
// No dependencies; every other file of the block but gdai_ram imports this package.
package gdai_pkg;

   localparam int DEF_SAMPLE_DEPTH = 512;
   localparam int DEF_STAMP_BITS   = 48;

   localparam int FIELD_STAMP_W = 48;
   localparam int RATE_W        = 24;
   localparam int DELTA_W       = 48;
   localparam int RET_W         = 24;
   localparam int MINQ_W        = 11;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [1:0] REG_ENABLE_DELTA = 2'd0;
   localparam logic [1:0] REG_FLU_FRAME    = 2'd1;
   localparam logic [1:0] REG_RETENTION    = 2'd2;
   localparam logic [1:0] REG_MIN_COVERAGE = 2'd3;

   localparam logic              RST_ENABLE_DELTA = 1'b1;
   localparam logic              RST_FLU_FRAME    = 1'b1;
   localparam logic [RET_W-1:0]  RST_RETENTION    = 24'd2000000;
   localparam logic [MINQ_W-1:0] RST_MIN_COVERAGE = 11'd717;
   localparam logic [MINQ_W-1:0] MINQ_FLOOR       = 11'd102;
   localparam logic [MINQ_W-1:0] MINQ_CEIL        = 11'd1024;

   localparam logic [RATE_W-1:0]  RATE_NEG_MIN  = 24'h800000;
   localparam logic [RATE_W-1:0]  RATE_POS_MAX  = 24'h7FFFFF;
   localparam logic [DELTA_W-1:0] DELTA_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [DELTA_W-1:0] DELTA_NEG_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic               enable_delta;
      logic               flu_frame;
      logic [RET_W-1:0]   retention_us;
      logic [MINQ_W-1:0]  min_coverage_q10;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S_CHECK,
      ST_S_RREAD,
      ST_S_RDATA,
      ST_Q_SETUP,
      ST_Q_HEAD,
      ST_Q_CHECK,
      ST_Q_READ,
      ST_Q_DATA,
      ST_Q_TAIL,
      ST_M_LO,
      ST_M_HI,
      ST_M_TERM,
      ST_M_ACC,
      ST_Q_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_STORE,
      OP_RET_READ,
      OP_RET_DROP,
      OP_Q_SETUP,
      OP_Q_HEAD,
      OP_Q_START,
      OP_Q_READ,
      OP_Q_EVAL,
      OP_Q_TAIL,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_TERM,
      OP_ACC,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      req_ready;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_mode;
      logic store_ok;
      logic ret_more;
      logic ret_drop;
      logic q_fail;
      logic q_skip;
      logic q_stop;
      logic q_last;
      logic q_end;
      logic tail_need;
      logic in_tail;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic [RATE_W-1:0] neg_sat24(input logic [RATE_W-1:0] v);
      logic [RATE_W-1:0] r;
      if (v == RATE_NEG_MIN) r = RATE_POS_MAX;
      else                   r = ~v + 1'b1;
      return r;
   endfunction

   function automatic logic [MINQ_W-1:0] clamp_minq(input logic [MINQ_W-1:0] v);
      logic [MINQ_W-1:0] r;
      if (v < MINQ_FLOOR)     r = MINQ_FLOOR;
      else if (v > MINQ_CEIL) r = MINQ_CEIL;
      else                    r = v;
      return r;
   endfunction

endpackage

### rtl/gdai_if.sv
// Valid/ready channel interfaces for sample/query items and integration results.
// Field widths come from gdai_pkg.
interface gdai_req_if;
   import gdai_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [FIELD_STAMP_W-1:0] sample_time_us;
   logic [FIELD_STAMP_W-1:0] window_start_us;
   logic [RATE_W-1:0]        rate_x;
   logic [RATE_W-1:0]        rate_y;
   logic [RATE_W-1:0]        rate_z;
   logic                     rates_finite;

   modport source (output valid, mode, sample_time_us, window_start_us, rate_x, rate_y,
                   rate_z, rates_finite, input ready);
   modport sink   (input valid, mode, sample_time_us, window_start_us, rate_x, rate_y,
                   rate_z, rates_finite, output ready);
endinterface

interface gdai_rsp_if;
   import gdai_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     delta_available;
   logic [DELTA_W-1:0]       delta_x;
   logic [DELTA_W-1:0]       delta_y;
   logic [DELTA_W-1:0]       delta_z;
   logic [FIELD_STAMP_W-1:0] covered_span_us;

   modport source (output valid, delta_available, delta_x, delta_y, delta_z, covered_span_us,
                   input ready);
   modport sink   (input valid, delta_available, delta_x, delta_y, delta_z, covered_span_us,
                   output ready);
endinterface

### rtl/gdai_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gdai_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/gdai_csr.sv
// APB-style configuration registers of the integrator.
// Depends on gdai_pkg.
module gdai_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gdai_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gdai_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gdai_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output gdai_pkg::cfg_type               cfg
);
   import gdai_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_fire;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_delta     <= RST_ENABLE_DELTA;
         cfg_ff.flu_frame        <= RST_FLU_FRAME;
         cfg_ff.retention_us     <= RST_RETENTION;
         cfg_ff.min_coverage_q10 <= RST_MIN_COVERAGE;
      end else if (wr_fire) begin
         case (reg_idx)
            REG_ENABLE_DELTA: cfg_ff.enable_delta     <= csr_pwdata[0];
            REG_FLU_FRAME:    cfg_ff.flu_frame        <= csr_pwdata[0];
            REG_RETENTION:    cfg_ff.retention_us     <= csr_pwdata[RET_W-1:0];
            REG_MIN_COVERAGE: cfg_ff.min_coverage_q10 <= csr_pwdata[MINQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ENABLE_DELTA: csr_prdata = CSR_DATA_W'(cfg_ff.enable_delta);
         REG_FLU_FRAME:    csr_prdata = CSR_DATA_W'(cfg_ff.flu_frame);
         REG_RETENTION:    csr_prdata = CSR_DATA_W'(cfg_ff.retention_us);
         REG_MIN_COVERAGE: csr_prdata = CSR_DATA_W'(cfg_ff.min_coverage_q10);
         default:          csr_prdata = '0;
      endcase
   end
endmodule

### rtl/gdai_ctrl.sv
// Controller state machine: sequences sample stores, retention and window integration.
// Depends on gdai_pkg; drives gdai_dp through dp_cmd_type.
module gdai_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  gdai_pkg::dp_status_type status,
   output gdai_pkg::dp_cmd_type    cmd
);
   import gdai_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = status.req_mode ? ST_Q_SETUP : ST_S_CHECK;
            end
         end
         ST_S_CHECK: begin
            cmd.op   = OP_STORE;
            state_in = status.store_ok ? ST_S_RREAD : ST_IDLE;
         end
         ST_S_RREAD: begin
            if (status.ret_more) begin
               cmd.op   = OP_RET_READ;
               state_in = ST_S_RDATA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_S_RDATA: begin
            if (status.ret_drop) begin
               cmd.op   = OP_RET_DROP;
               state_in = ST_S_RREAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_SETUP: begin
            cmd.op   = OP_Q_SETUP;
            state_in = ST_Q_HEAD;
         end
         ST_Q_HEAD: begin
            cmd.op   = OP_Q_HEAD;
            state_in = ST_Q_CHECK;
         end
         ST_Q_CHECK: begin
            cmd.op   = OP_Q_START;
            state_in = status.q_fail ? ST_Q_DONE : ST_Q_READ;
         end
         ST_Q_READ: begin
            cmd.op   = OP_Q_READ;
            state_in = ST_Q_DATA;
         end
         ST_Q_DATA: begin
            cmd.op = OP_Q_EVAL;
            if (status.q_skip)      state_in = status.q_last ? ST_Q_TAIL : ST_Q_READ;
            else if (status.q_stop) state_in = ST_Q_TAIL;
            else                    state_in = ST_M_LO;
         end
         ST_Q_TAIL: begin
            if (status.tail_need) begin
               cmd.op   = OP_Q_TAIL;
               state_in = ST_M_LO;
            end else begin
               state_in = ST_Q_DONE;
            end
         end
         ST_M_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_M_HI;
         end
         ST_M_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_M_TERM;
         end
         ST_M_TERM: begin
            cmd.op   = OP_TERM;
            state_in = ST_M_ACC;
         end
         ST_M_ACC: begin
            cmd.op = OP_ACC;
            if (status.in_tail)    state_in = ST_Q_DONE;
            else if (status.q_end) state_in = ST_Q_TAIL;
            else                   state_in = ST_Q_READ;
         end
         ST_Q_DONE: begin
            if (!status.rsp_busy) begin
               cmd.op   = OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### rtl/gdai_dp.sv
// Datapath: sample ring in RAM, window clipping, rate-times-interval terms and sums.
// Depends on gdai_pkg, gdai_if and gdai_ram; controlled by gdai_ctrl.
module gdai_dp #(
   parameter int SAMPLE_DEPTH = gdai_pkg::DEF_SAMPLE_DEPTH,
   parameter int STAMP_BITS   = gdai_pkg::DEF_STAMP_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gdai_pkg::dp_cmd_type    cmd,
   output gdai_pkg::dp_status_type status,
   input  gdai_pkg::cfg_type       cfg,
   gdai_req_if.sink                req,
   gdai_rsp_if.source              rsp
);
   import gdai_pkg::*;

   localparam int IW  = $clog2(SAMPLE_DEPTH);
   localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
   localparam int SB  = STAMP_BITS;
   localparam int MW  = SB + 3 * RATE_W;
   localparam int PW  = SB + MINQ_W;

   // latched item
   logic [SB-1:0]     in_stamp_ff, in_start_ff;
   logic [RATE_W-1:0] in_rate_ff [3];
   logic              in_finite_ff;

   // ring state
   logic [IW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [SB-1:0] newest_ff, keep_from_ff;

   // query state
   logic          fail_ff, tail_ff;
   logic [SB-1:0] is_ff, ie_ff, total_ff, cursor_ff, dt_ff;
   logic [PW-1:0] cov_prod_ff;
   logic [IW-1:0] ptr_ff;
   logic [CW-1:0] idx_ff;
   logic [RATE_W-1:0]  omega_ff [3];
   logic [RATE_W-1:0]  op_rate_ff [3];
   logic [DELTA_W-1:0] plo_ff [3], phi_ff [3], term_ff [3], acc_ff [3];

   // result register
   logic               rsp_valid_ff, rsp_avail_ff;
   logic [DELTA_W-1:0] rsp_dx_ff, rsp_dy_ff, rsp_dz_ff, rsp_cov_ff;

   // RAM
   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [MW-1:0] ram_wdata, ram_rdata;
   logic [SB-1:0] rd_stamp;
   logic [RATE_W-1:0] rd_rate [3];

   logic              full, store_ok;
   logic [IW-1:0]     head_inc, ptr_inc, tail_pos;
   logic [IW:0]       pos_sum;
   logic [RATE_W-1:0] st_y, st_z;
   logic [SB-1:0]     ret_ext, covered;
   logic [63:0]       dt_ext;
   logic              dt_big;
   logic [RATE_W-1:0] mag [3];
   logic [DELTA_W-1:0] term_in [3], acc_in [3];
   logic              cov_ok;

   gdai_ram #(.WIDTH(MW), .DEPTH(SAMPLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_stamp   = ram_rdata[MW-1 -: SB];
   assign rd_rate[0] = ram_rdata[3*RATE_W-1 -: RATE_W];
   assign rd_rate[1] = ram_rdata[2*RATE_W-1 -: RATE_W];
   assign rd_rate[2] = ram_rdata[RATE_W-1:0];

   assign head_inc = (head_ff == IW'(SAMPLE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign ptr_inc  = (ptr_ff  == IW'(SAMPLE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign full     = (count_ff == CW'(SAMPLE_DEPTH));
   assign pos_sum  = (IW+1)'(head_ff) + (IW+1)'(count_ff);
   assign tail_pos = (pos_sum >= (IW+1)'(SAMPLE_DEPTH)) ?
                     IW'(pos_sum - (IW+1)'(SAMPLE_DEPTH)) : IW'(pos_sum);

   assign store_ok = (in_stamp_ff != '0) && in_finite_ff &&
                     !((count_ff != '0) && (in_stamp_ff <= newest_ff));
   assign st_y     = cfg.flu_frame ? neg_sat24(in_rate_ff[1]) : in_rate_ff[1];
   assign st_z     = cfg.flu_frame ? neg_sat24(in_rate_ff[2]) : in_rate_ff[2];
   assign ret_ext  = SB'(cfg.retention_us);

   assign ram_we    = (cmd.op == OP_STORE) && store_ok;
   assign ram_waddr = full ? head_ff : tail_pos;
   assign ram_wdata = {in_stamp_ff, in_rate_ff[0], st_y, st_z};
   assign ram_re    = (cmd.op == OP_RET_READ) || (cmd.op == OP_Q_SETUP) ||
                      (cmd.op == OP_Q_READ);
   assign ram_raddr = (cmd.op == OP_Q_READ) ? ptr_ff : head_ff;

   assign covered = ie_ff - is_ff;
   assign cov_ok  = {1'b0, covered, 10'd0} >= cov_prod_ff;

   assign dt_ext = 64'(dt_ff);
   assign dt_big = |dt_ext[63:48];

   // per-axis saturated term and sum
   always_comb begin
      logic [DELTA_W:0]   sum49;
      logic [DELTA_W:0]   acc49;
      logic               sat;
      logic [DELTA_W-1:0] p;
      for (int k = 0; k < 3; k++) begin
         mag[k] = op_rate_ff[k][RATE_W-1] ? (~op_rate_ff[k] + 1'b1) : op_rate_ff[k];
         sum49  = {1'b0, phi_ff[k][23:0], 24'd0} + {1'b0, plo_ff[k]};
         sat    = (dt_big && (mag[k] != '0)) || (phi_ff[k][47:24] != '0) ||
                  (sum49 >= {2'b01, 47'd0});
         p      = sat ? DELTA_NEG_MIN : sum49[DELTA_W-1:0];
         if (op_rate_ff[k][RATE_W-1]) term_in[k] = ~p + 1'b1;
         else                         term_in[k] = sat ? DELTA_POS_MAX : p;
         acc49  = {acc_ff[k][DELTA_W-1], acc_ff[k]} + {term_ff[k][DELTA_W-1], term_ff[k]};
         if (acc49[DELTA_W] != acc49[DELTA_W-1])
            acc_in[k] = acc49[DELTA_W] ? DELTA_NEG_MIN : DELTA_POS_MAX;
         else
            acc_in[k] = acc49[DELTA_W-1:0];
      end
   end

   always_comb begin
      status.req_valid = req.valid;
      status.req_mode  = req.mode;
      status.store_ok  = store_ok;
      status.ret_more  = (count_ff > CW'(1));
      status.ret_drop  = (rd_stamp < keep_from_ff);
      status.q_fail    = fail_ff || (ie_ff <= is_ff);
      status.q_skip    = (rd_stamp <= is_ff);
      status.q_stop    = (rd_stamp >= ie_ff);
      status.q_last    = ((idx_ff + 1'b1) == count_ff);
      status.q_end     = (idx_ff == count_ff);
      status.tail_need = (ie_ff > cursor_ff);
      status.in_tail   = tail_ff;
      status.rsp_busy  = rsp_valid_ff && !rsp.ready;
   end

   assign req.ready = cmd.req_ready;

   // ring control
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (cmd.op)
            OP_STORE: begin
               if (store_ok) begin
                  if (full) head_ff  <= head_inc;
                  else      count_ff <= count_ff + 1'b1;
               end
            end
            OP_RET_DROP: begin
               head_ff  <= head_inc;
               count_ff <= count_ff - 1'b1;
            end
            default: ;
         endcase
      end
   end

   // payload and query registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            in_stamp_ff   <= SB'(req.sample_time_us);
            in_start_ff   <= SB'(req.window_start_us);
            in_rate_ff[0] <= req.rate_x;
            in_rate_ff[1] <= req.rate_y;
            in_rate_ff[2] <= req.rate_z;
            in_finite_ff  <= req.rates_finite;
         end
         OP_STORE: begin
            if (store_ok) begin
               newest_ff    <= in_stamp_ff;
               keep_from_ff <= (in_stamp_ff > ret_ext) ? in_stamp_ff - ret_ext : '0;
            end
         end
         OP_Q_SETUP: begin
            fail_ff <= (in_stamp_ff <= in_start_ff) || (count_ff == '0);
         end
         OP_Q_HEAD: begin
            fail_ff  <= fail_ff || (newest_ff <= in_start_ff) || (rd_stamp >= in_stamp_ff);
            is_ff    <= (in_start_ff > rd_stamp) ? in_start_ff : rd_stamp;
            ie_ff    <= (in_stamp_ff < newest_ff) ? in_stamp_ff : newest_ff;
            total_ff <= in_stamp_ff - in_start_ff;
         end
         OP_Q_START: begin
            fail_ff     <= fail_ff || (ie_ff <= is_ff);
            cursor_ff   <= is_ff;
            ptr_ff      <= head_ff;
            idx_ff      <= '0;
            tail_ff     <= 1'b0;
            cov_prod_ff <= PW'(clamp_minq(cfg.min_coverage_q10)) * PW'(total_ff);
            for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
         end
         OP_Q_EVAL: begin
            ptr_ff <= ptr_inc;
            idx_ff <= idx_ff + 1'b1;
            if (rd_stamp <= is_ff) begin
               for (int k = 0; k < 3; k++) omega_ff[k] <= rd_rate[k];
            end else if (rd_stamp < ie_ff) begin
               dt_ff     <= rd_stamp - cursor_ff;
               cursor_ff <= rd_stamp;
               for (int k = 0; k < 3; k++) begin
                  op_rate_ff[k] <= omega_ff[k];
                  omega_ff[k]   <= rd_rate[k];
               end
            end
         end
         OP_Q_TAIL: begin
            dt_ff   <= ie_ff - cursor_ff;
            tail_ff <= 1'b1;
            for (int k = 0; k < 3; k++) op_rate_ff[k] <= omega_ff[k];
         end
         OP_MUL_LO: begin
            for (int k = 0; k < 3; k++) plo_ff[k] <= DELTA_W'(mag[k]) * DELTA_W'(dt_ext[23:0]);
         end
         OP_MUL_HI: begin
            for (int k = 0; k < 3; k++) phi_ff[k] <= DELTA_W'(mag[k]) * DELTA_W'(dt_ext[47:24]);
         end
         OP_TERM: begin
            for (int k = 0; k < 3; k++) term_ff[k] <= term_in[k];
         end
         OP_ACC: begin
            for (int k = 0; k < 3; k++) acc_ff[k] <= acc_in[k];
         end
         OP_RESP: begin
            rsp_avail_ff <= !fail_ff && cfg.enable_delta && cov_ok;
            rsp_cov_ff   <= fail_ff ? '0 : DELTA_W'(covered);
            rsp_dx_ff    <= (!fail_ff && cfg.enable_delta && cov_ok) ? acc_ff[0] : '0;
            rsp_dy_ff    <= (!fail_ff && cfg.enable_delta && cov_ok) ? acc_ff[1] : '0;
            rsp_dz_ff    <= (!fail_ff && cfg.enable_delta && cov_ok) ? acc_ff[2] : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)                 rsp_valid_ff <= 1'b0;
      else if (cmd.op == OP_RESP) rsp_valid_ff <= 1'b1;
      else if (rsp.ready)        rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.delta_available = rsp_avail_ff;
   assign rsp.delta_x         = rsp_dx_ff;
   assign rsp.delta_y         = rsp_dy_ff;
   assign rsp.delta_z         = rsp_dz_ff;
   assign rsp.covered_span_us = rsp_cov_ff;
endmodule

### rtl/gyro_delta_angle_integrator_core.sv
// Top level of the gyro delta-angle integrator: CSR block, controller and datapath.
// Depends on gdai_pkg, gdai_if, gdai_csr, gdai_ctrl, gdai_dp and gdai_ram.
//
// Stores time-stamped 3-axis gyro rates (codes of 2^-16 rad/s) in a ring of SAMPLE_DEPTH
// entries held in one RAM, and answers window queries with the zero-order-hold integral of
// the rates over the window clipped to the stored span (rate code times microseconds,
// saturated to 48 signed bits). Items with mode 0 are samples, mode 1 are queries; only a
// query produces a result transfer. The block works on one item at a time. A sample is
// checked and, if accepted, stored; then, while more than one entry remains, the oldest
// entry is read and dropped if it lies before the retention window. A query reads the
// oldest entry and checks its window; one that fails posts its result at once. Otherwise
// the walk reads the ring through the single RAM read port: an entry at or before the
// clipped start only updates the held rate, one at or past the clipped end stops it, and
// each one inside closes an interval whose term (two-pass 24x24 multipliers per axis) is
// formed and summed; a closing interval up to the clipped end is added when not empty,
// then the result is posted. A finished result waits in an output register; the next
// item is taken meanwhile, and a later query holds its result until the earlier transfer
// completes. The sample RAM needs no clearing pass after reset: only written entries are
// ever used. Write configuration only while the block is idle.
module gyro_delta_angle_integrator_core #(
   parameter int SAMPLE_DEPTH = gdai_pkg::DEF_SAMPLE_DEPTH,
   parameter int STAMP_BITS   = gdai_pkg::DEF_STAMP_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   gdai_req_if.sink                        req_ch,
   gdai_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gdai_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gdai_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gdai_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import gdai_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers, written over the APB-style port
   gdai_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequence stores, retention drops and the window walk
   gdai_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // sample ring, clipping, term arithmetic and the result register
   gdai_dp #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH),
      .STAMP_BITS   (STAMP_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .cfg    (cfg),
      .req    (req_ch),
      .rsp    (rsp_ch)
   );
endmodule
